FILE: sv/sslt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list table package
// Sizes, operation and status codes, and the per-cell control and flag types.
// ----------------------------------------------------------------------------
package sslt_pkg;

  localparam int DEPTH       = 16;
  localparam int ENTRY_WIDTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int STATUS_W    = 2;

  typedef logic [1:0] op_t;
  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_DELETE = 2'd2;
  localparam op_t OP_SEARCH = 2'd3;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

  // Row-wide action broadcast to the cells
  typedef logic [1:0] act_t;
  localparam act_t ACT_NONE   = 2'd0;
  localparam act_t ACT_WRITE  = 2'd1;
  localparam act_t ACT_INSERT = 2'd2;
  localparam act_t ACT_DELETE = 2'd3;

  typedef struct packed {
    logic load_key;
    logic take_lower;
    logic take_upper;
  } cell_ctl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

endpackage

FILE: sv/sslt_ifs.sv
// ----------------------------------------------------------------------------
// Sorted list table channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface sslt_req_if import sslt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  op_t                    operation;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface sslt_res_if import sslt_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [IDX_W-1:0] position;
  logic [CNT_W-1:0] fill_count;

  modport source (output valid, status, position, fill_count, input ready);
  modport sink   (input valid, status, position, fill_count, output ready);
endinterface

interface sslt_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: sv/sslt_cell.sv
// ----------------------------------------------------------------------------
// Sorted list table cell
// One table entry: loads the key or a neighbor's entry, compares with the key.
// ----------------------------------------------------------------------------
module sslt_cell import sslt_pkg::*; (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic                   cmp_signed,
  input  logic [ENTRY_WIDTH-1:0] key,
  input  logic [ENTRY_WIDTH-1:0] lower,
  input  logic [ENTRY_WIDTH-1:0] upper,
  output logic [ENTRY_WIDTH-1:0] entry,
  output cell_flag_t             flag
);

  logic [ENTRY_WIDTH-1:0] sign_mask;
  logic [ENTRY_WIDTH-1:0] a_biased;
  logic [ENTRY_WIDTH-1:0] k_biased;

  always_ff @(posedge clk) begin
    if (ctl.load_key) begin
      entry <= key;
    end else if (ctl.take_lower) begin
      entry <= lower;
    end else if (ctl.take_upper) begin
      entry <= upper;
    end
  end

  // signed order = unsigned order with the sign bits flipped
  assign sign_mask = ENTRY_WIDTH'(cmp_signed) << (ENTRY_WIDTH - 1);
  assign a_biased  = entry ^ sign_mask;
  assign k_biased  = key ^ sign_mask;
  assign flag.lt   = a_biased < k_biased;
  assign flag.eq   = entry == key;

endmodule

FILE: sv/sorted_sequential_list_table_core.sv
// ----------------------------------------------------------------------------
// Sorted sequential list table core
// Fixed-depth entry table held in a row of cells, with a fill count, serving
// append, sorted insert, delete-first-equal and search-first-equal requests.
// ----------------------------------------------------------------------------
// The table lives in a row of DEPTH cells, one entry each. Every cell compares
// its entry with the latched key every cycle, and on command loads the key or
// its lower or upper neighbor's entry, so the whole tail shifts together in
// either direction. One request is worked at a time. Append, delete and
// search latch the key, act on the cell flags and present the result, and so
// does a sorted insert into an empty or a full table. Any other sorted insert
// latches the key and runs binary-search probes, with an exit step when the
// search ends without a hit, then places the key and presents the result.
// At most log2(DEPTH) - 1 probes are needed: the search picks one cell's
// flags per cycle. The next request is accepted as
// soon as the core is back in idle, while an untaken result still waits in the
// output register; a new result is held until that register frees up.
// The compare mode register (cfg.data, 0 unsigned, 1 two's complement) is
// always ready and must only be written while the core is idle. Entries come
// out of reset undefined; only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module sorted_sequential_list_table_core import sslt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sslt_req_if.sink    request,
  sslt_res_if.source  result,
  sslt_cfg_if.sink    cfg
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RUN    = 3'd1;  // act on flags of the latched key
  localparam logic [2:0] S_SEARCH = 3'd2;  // one binary-search probe per cycle
  localparam logic [2:0] S_PLACE  = 3'd3;  // insert at probe slot or one past it
  localparam logic [2:0] S_DONE   = 3'd4;  // hand result to output register

  logic [2:0]             state, state_next;
  op_t                    op;
  logic [ENTRY_WIDTH-1:0] key;
  logic [CNT_W-1:0]       count, count_next;
  logic                   cmp_signed;

  // Binary-search bounds, signed since high can drop to -1
  logic signed [IDX_W:0]  low, low_next;
  logic signed [IDX_W:0]  high, high_next;
  logic [IDX_W-1:0]       mid, mid_next;

  status_t                res_status, res_status_next;
  logic [IDX_W-1:0]       res_pos, res_pos_next;

  logic                   out_valid;
  status_t                out_status;
  logic [IDX_W-1:0]       out_pos;
  logic [CNT_W-1:0]       out_count;
  logic                   out_load;

  // Row of cells
  logic [ENTRY_WIDTH-1:0] ent [DEPTH];
  cell_flag_t             flags [DEPTH];
  cell_ctl_t              ctl [DEPTH];
  logic [DEPTH-1:0]       lt_vec;
  logic [DEPTH-1:0]       eq_vec;
  act_t                   act;
  logic [IDX_W-1:0]       act_pos;

  // Search helpers
  logic                   full;
  logic                   found;
  logic [IDX_W-1:0]       found_idx;
  logic [IDX_W:0]         mid_sum;
  logic [IDX_W-1:0]       mid_cur;
  logic [IDX_W-1:0]       ins_pos;

  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    logic [ENTRY_WIDTH-1:0] lower;
    logic [ENTRY_WIDTH-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = key;
    end else begin : g_lower
      assign lower = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = key;
    end else begin : g_upper
      assign upper = ent[i+1];
    end

    // Decode the row action into this cell's load select
    always_comb begin
      ctl[i] = '0;
      case (act)
        ACT_WRITE: begin
          ctl[i].load_key = act_pos == IDX_W'(i);
        end
        ACT_INSERT: begin
          ctl[i].load_key   = act_pos == IDX_W'(i);
          ctl[i].take_lower = IDX_W'(i) > act_pos;
        end
        ACT_DELETE: begin
          ctl[i].take_upper = IDX_W'(i) >= act_pos;
        end
        default: begin
        end
      endcase
    end

    sslt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .cmp_signed (cmp_signed),
      .key        (key),
      .lower      (lower),
      .upper      (upper),
      .entry      (ent[i]),
      .flag       (flags[i])
    );

    assign lt_vec[i] = flags[i].lt;
    // only held entries take part in the equality scan
    assign eq_vec[i] = flags[i].eq && (CNT_W'(i) < count);
  end

  // First equal held entry
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if (eq_vec[j]) begin
        found     = 1'b1;
        found_idx = IDX_W'(j);
      end
    end
  end

  assign full    = count == CNT_W'(DEPTH);
  assign mid_sum = {1'b0, low[IDX_W-1:0]} + {1'b0, high[IDX_W-1:0]};
  assign mid_cur = mid_sum[IDX_W:1];
  // step past the probed entry when it is smaller than the key
  assign ins_pos = mid + IDX_W'(lt_vec[mid]);

  assign out_load = (state == S_DONE) && (!out_valid || result.ready);

  always_comb begin
    state_next      = state;
    count_next      = count;
    low_next        = low;
    high_next       = high;
    mid_next        = mid;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    act             = ACT_NONE;
    act_pos         = '0;

    case (state)
      S_IDLE: begin
        if (request.valid) begin
          state_next = S_RUN;
        end
      end

      S_RUN: begin
        res_status_next = ST_DONE;
        res_pos_next    = '0;
        state_next      = S_DONE;
        case (op)
          OP_APPEND: begin
            if (full) begin
              res_status_next = ST_FULL;
            end else begin
              act          = ACT_WRITE;
              act_pos      = count[IDX_W-1:0];
              count_next   = count + 1'b1;
              res_pos_next = count[IDX_W-1:0];
            end
          end
          OP_INSERT: begin
            if (full) begin
              res_status_next = ST_FULL;
            end else if (count == '0) begin
              act        = ACT_WRITE;
              act_pos    = '0;
              count_next = count + 1'b1;
            end else begin
              low_next   = '0;
              high_next  = (IDX_W+1)'(count - 1'b1);
              mid_next   = '0;
              state_next = S_SEARCH;
            end
          end
          default: begin  // delete or search
            if (!found) begin
              res_status_next = ST_NOT_FOUND;
            end else begin
              res_pos_next = found_idx;
              if (op == OP_DELETE) begin
                act        = ACT_DELETE;
                act_pos    = found_idx;
                count_next = count - 1'b1;
              end
            end
          end
        endcase
      end

      S_SEARCH: begin
        if (low < high) begin
          mid_next = mid_cur;
          if (eq_vec[mid_cur]) begin
            state_next = S_PLACE;  // exact hit ends the search
          end else if (!lt_vec[mid_cur]) begin
            high_next = (IDX_W+1)'($signed({1'b0, mid_cur}) - 1);
          end else begin
            low_next = {1'b0, mid_cur} + (IDX_W+1)'(1);
          end
        end else begin
          if (low == high) begin
            mid_next = low[IDX_W-1:0];
          end
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        act             = ACT_INSERT;
        act_pos         = ins_pos;
        count_next      = count + 1'b1;
        res_status_next = ST_DONE;
        res_pos_next    = ins_pos;
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      cmp_signed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg.valid) begin
        cmp_signed <= cfg.data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && request.valid) begin
      op  <= request.operation;
      key <= ENTRY_WIDTH'(request.value);
    end
    low        <= low_next;
    high       <= high_next;
    mid        <= mid_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    if (out_load) begin
      out_status <= res_status;
      out_pos    <= res_pos;
      out_count  <= count;
    end
  end

  assign request.ready     = state == S_IDLE;
  assign cfg.ready         = 1'b1;
  assign result.valid      = out_valid;
  assign result.status     = out_status;
  assign result.position   = out_pos;
  assign result.fill_count = out_count;

endmodule
